/* hdl/lmfb_pkg.sv */
// ----------------------------------------------------------------------------
// lmfb_pkg
// Shared types and constants of the LED matrix frame buffer: command codes,
// item structs, sequencer states and the control bundle of the row unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfb_pkg;

	// Matrix geometry and register reset values
	localparam int          ROW_W          = 8;
	localparam int          COL_W          = 3;
	localparam int          CFG_W          = 5;
	localparam int          MAX_ROWS_DEF   = 16;
	localparam logic [CFG_W-1:0] ROWS_IN_USE_RST = 5'd8;

	// Command codes carried in req_type
	typedef enum logic [4:0] {
		CMD_SET_PX    = 5'd0,
		CMD_GET_PX    = 5'd1,
		CMD_TGL_PX    = 5'd2,
		CMD_INV_ALL   = 5'd3,
		CMD_INV_ROW   = 5'd4,
		CMD_INV_COL   = 5'd5,
		CMD_CLR_ROW   = 5'd6,
		CMD_CLR_COL   = 5'd7,
		CMD_SWAP_ROWS = 5'd8,
		CMD_COPY_ROW  = 5'd9,
		CMD_COPY_COL  = 5'd10,
		CMD_SWAP_COLS = 5'd11,
		CMD_ROTL_ROW  = 5'd12,
		CMD_ROTR_ROW  = 5'd13,
		CMD_ROTL_ALL  = 5'd14,
		CMD_ROTR_ALL  = 5'd15,
		CMD_SCROLL_UP = 5'd16,
		CMD_SCROLL_DN = 5'd17,
		CMD_CLR_ALL   = 5'd18,
		CMD_READ_ROW  = 5'd19
	} cmd_e;

	// Input item
	typedef struct packed {
		logic [4:0]       req_type;
		logic [3:0]       row_index;
		logic [COL_W-1:0] col_index;
		logic [3:0]       dest_row;
		logic [COL_W-1:0] dest_col;
		logic             pixel_value;
		logic [COL_W-1:0] rotate_count;
	} req_t;

	// Result item
	typedef struct packed {
		logic             pixel_out;
		logic [ROW_W-1:0] row_out;
	} rsp_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRELOAD,
		ST_SWEEP,
		ST_SWAP_TAIL,
		ST_FINISH
	} state_e;

	// Control bundle for the shared row unit
	typedef struct packed {
		cmd_e             cmd;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] dcol;
		logic             pval;
		logic [COL_W-1:0] cnt;
	} alu_ctrl_t;

endpackage

`default_nettype wire

/* hdl/lmfb_row_alu.sv */
// ----------------------------------------------------------------------------
// lmfb_row_alu
// Shared row unit: applies one command to one row byte per cycle (pixel and
// column bit ops, invert, clear, barrel rotate) or passes the carried row.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfb_row_alu
	import lmfb_pkg::*;
(
	input  alu_ctrl_t        ctrl,
	input  logic [ROW_W-1:0] row_in,
	input  logic [ROW_W-1:0] carry,
	output logic [ROW_W-1:0] row_res
);

	logic [ROW_W-1:0]   cbit;
	logic [2*ROW_W-1:0] wide_l;
	logic [2*ROW_W-1:0] wide_r;

	// Column mask and rotate by shifting a doubled byte
	assign cbit   = ROW_W'(1) << ctrl.col;
	assign wide_l = {row_in, row_in} >> ctrl.cnt;
	assign wide_r = {row_in, row_in} << ctrl.cnt;

	// Decode the command into the new row byte
	always_comb begin
		row_res = row_in;
		unique case (ctrl.cmd) inside
			CMD_SET_PX: begin
				row_res = ctrl.pval ? (row_in | cbit) : (row_in & ~cbit);
			end
			CMD_TGL_PX, CMD_INV_COL: begin
				row_res = row_in ^ cbit;
			end
			CMD_INV_ALL, CMD_INV_ROW: begin
				row_res = ~row_in;
			end
			CMD_CLR_ROW, CMD_CLR_ALL: begin
				row_res = '0;
			end
			CMD_CLR_COL: begin
				row_res = row_in & ~cbit;
			end
			CMD_COPY_COL: begin
				row_res[ctrl.dcol] = row_in[ctrl.col];
			end
			CMD_SWAP_COLS: begin
				row_res[ctrl.col]  = row_in[ctrl.dcol];
				row_res[ctrl.dcol] = row_in[ctrl.col];
			end
			CMD_ROTL_ROW, CMD_ROTL_ALL: begin
				row_res = wide_l[ROW_W-1:0];
			end
			CMD_ROTR_ROW, CMD_ROTR_ALL: begin
				row_res = wide_r[2*ROW_W-1:ROW_W];
			end
			CMD_SWAP_ROWS, CMD_COPY_ROW, CMD_SCROLL_UP, CMD_SCROLL_DN: begin
				row_res = carry;
			end
			default: begin
				row_res = row_in;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/led_matrix_frame_buffer.sv */
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer
// Sequence per item: get, read row and unknown commands go straight to
// finish; single-row commands sweep one row; row copy, row swap and scrolls
// preload a row first, row swap adds a tail write; whole-frame commands sweep
// the rows in use. One item at a time: the next is taken the cycle after the
// result loads. Reset clears every row at once and sets rows_in_use to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_frame_buffer
	import lmfb_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W  = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;

	logic [ROW_W-1:0]  frame_q [MAX_ROWS];
	logic [CFG_W-1:0]  rows_q;
	state_e            state_q, state_nxt;
	req_t              item_q;
	logic              row_ok_q;
	logic [ADDR_W-1:0] idx_q, last_q, pre_q;
	logic              dir_up_q;
	logic [ROW_W-1:0]  carry_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [CNT_W-1:0]  n_eff;
	logic              row_ok_in, drow_ok_in;
	logic [ADDR_W-1:0] last_all, row_addr_in, drow_addr_in, row_addr_q;
	state_e            setup_st;
	logic [ADDR_W-1:0] setup_idx, setup_last, setup_pre;
	logic              setup_up;
	logic              accept, sweep_done, out_load;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [ROW_W-1:0]  rd_data, wr_data, alu_res;
	logic              wr_en, wr_from_carry;
	alu_ctrl_t         alu_ctrl;

	// Rows in use, clamped to the store depth
	always_comb begin
		n_eff = CNT_W'(rows_q);
		if (n_eff > CNT_W'(MAX_ROWS)) begin
			n_eff = CNT_W'(MAX_ROWS);
		end
	end

	assign row_ok_in    = CNT_W'(in_data.row_index) < n_eff;
	assign drow_ok_in   = CNT_W'(in_data.dest_row) < n_eff;
	assign last_all     = ADDR_W'(n_eff - CNT_W'(1));
	assign row_addr_in  = ADDR_W'(in_data.row_index);
	assign drow_addr_in = ADDR_W'(in_data.dest_row);
	assign row_addr_q   = ADDR_W'(item_q.row_index);
	assign accept       = in_valid && in_ready;
	assign sweep_done   = (idx_q == last_q);

	// Decode an incoming item into its row range and first state
	always_comb begin
		setup_st   = ST_FINISH;
		setup_idx  = row_addr_in;
		setup_last = row_addr_in;
		setup_pre  = row_addr_in;
		setup_up   = 1'b1;
		unique case (cmd_e'(in_data.req_type)) inside
			CMD_INV_ALL, CMD_INV_COL, CMD_CLR_COL, CMD_COPY_COL, CMD_SWAP_COLS,
			CMD_ROTL_ALL, CMD_ROTR_ALL, CMD_CLR_ALL: begin
				setup_idx  = '0;
				setup_last = last_all;
				if (n_eff != '0) begin
					setup_st = ST_SWEEP;
				end
			end
			CMD_SET_PX, CMD_TGL_PX, CMD_INV_ROW, CMD_CLR_ROW,
			CMD_ROTL_ROW, CMD_ROTR_ROW: begin
				if (row_ok_in) begin
					setup_st = ST_SWEEP;
				end
			end
			CMD_SWAP_ROWS, CMD_COPY_ROW: begin
				setup_idx  = drow_addr_in;
				setup_last = drow_addr_in;
				if (row_ok_in && drow_ok_in) begin
					setup_st = ST_PRELOAD;
				end
			end
			CMD_SCROLL_UP: begin
				setup_pre  = last_all;
				setup_idx  = '0;
				setup_last = last_all;
				if (n_eff != '0) begin
					setup_st = ST_PRELOAD;
				end
			end
			CMD_SCROLL_DN: begin
				setup_pre  = '0;
				setup_idx  = last_all;
				setup_last = '0;
				setup_up   = 1'b0;
				if (n_eff != '0) begin
					setup_st = ST_PRELOAD;
				end
			end
			default: begin
				setup_st = ST_FINISH;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = setup_st;
				end
			end
			ST_PRELOAD: begin
				state_nxt = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (sweep_done) begin
					state_nxt = (item_q.req_type == CMD_SWAP_ROWS) ? ST_SWAP_TAIL : ST_FINISH;
				end
			end
			ST_SWAP_TAIL: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: read address, write strobe and output load
	always_comb begin
		in_ready      = 1'b0;
		rd_addr       = idx_q;
		wr_en         = 1'b0;
		wr_addr       = idx_q;
		wr_from_carry = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_PRELOAD: begin
				rd_addr = pre_q;
			end
			ST_SWEEP: begin
				wr_en = 1'b1;
			end
			ST_SWAP_TAIL: begin
				wr_en         = 1'b1;
				wr_addr       = row_addr_q;
				wr_from_carry = 1'b1;
			end
			ST_FINISH: begin
				rd_addr  = row_addr_q;
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Single row read port; addresses past the store read as zero
	assign rd_data = (CNT_W'(rd_addr) < CNT_W'(MAX_ROWS)) ? frame_q[rd_addr] : '0;

	assign alu_ctrl = '{
		cmd:  cmd_e'(item_q.req_type),
		col:  item_q.col_index,
		dcol: item_q.dest_col,
		pval: item_q.pixel_value,
		cnt:  item_q.rotate_count
	};

	lmfb_row_alu u_row_alu (
		.ctrl    (alu_ctrl),
		.row_in  (rd_data),
		.carry   (carry_q),
		.row_res (alu_res)
	);

	assign wr_data = wr_from_carry ? carry_q : alu_res;

	// Frame store: cleared at reset, one row written per cycle while the write strobe is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ROWS; i++) begin
				frame_q[i] <= '0;
			end
		end else if (wr_en) begin
			frame_q[wr_addr] <= wr_data;
		end
	end

	// Control state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= ROWS_IN_USE_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				rows_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, row walk, carry and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= in_data;
			row_ok_q <= row_ok_in;
			idx_q    <= setup_idx;
			last_q   <= setup_last;
			pre_q    <= setup_pre;
			dir_up_q <= setup_up;
		end else if (state_q == ST_SWEEP && !sweep_done) begin
			idx_q <= dir_up_q ? idx_q + ADDR_W'(1) : idx_q - ADDR_W'(1);
		end
		// Hold the row just read for moves and swaps
		if (state_q == ST_PRELOAD || state_q == ST_SWEEP) begin
			carry_q <= rd_data;
		end
		if (out_load) begin
			out_q.pixel_out <= (item_q.req_type == CMD_GET_PX) && row_ok_q
				&& rd_data[item_q.col_index];
			out_q.row_out   <= row_ok_q ? rd_data : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
